// ===== hdl/cbpe_pkg.sv =====
// shared types and constants for the cubic bezier point evaluator
// register map of the control points and the lerp stage control bundle
// no dependencies
package cbpe_pkg;

  // configuration port geometry
  localparam int unsigned NUM_REGS  = 8;
  localparam int unsigned REG_IDX_W = 3;
  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned APB_DATA_W = 32;

  // register indexes, one per control point coordinate
  localparam logic [REG_IDX_W-1:0] REG_P0_X = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_P0_Y = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_P1_X = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_P1_Y = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_P2_X = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_P2_Y = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_P3_X = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_P3_Y = 3'd7;

  // load enables for the two register stages of one lerp
  typedef struct packed {
    logic mul_en;
    logic sum_en;
  } lerp_ctrl_t;

endpackage

// ===== hdl/cubic_bezier_point_eval.sv =====
// top level of the cubic bezier point evaluator: control point registers,
// apb-style register port and the de casteljau pipeline
// depends on cbpe_pkg and cbpe_lerp
//
// usage
//   - write the four control points (x and y per point) over the apb-style
//     port while no beat is in flight; pready is always high, reads return
//     the stored coordinate
//   - send one curve parameter t per beat on the input channel, 1.0 being
//     1 << PARAM_FRAC_BITS; values above 1.0 are clamped to 1.0
//   - each input beat gives one output beat with the curve point,
//     fraction truncated to whole pixels
//   - seven register stages: one stage clamps t, then each of the three
//     interpolation levels takes a multiply stage and a sum stage; a beat
//     passes the clamp stage and then the multiply and sum stages of each
//     level in order before out_valid_o rises with its point
//   - throughput is one beat per cycle while the receiver takes beats; every stage has its own valid bit
//     and loads when it is empty or its successor loads, so bubbles close up
//   - when the receiver stalls the pipeline fills stage by stage and
//     in_ready_o drops only once every stage holds a beat
//   - reset clears all valid bits and sets every control point to zero
module cubic_bezier_point_eval import cbpe_pkg::*; #(
  parameter int unsigned PARAM_FRAC_BITS = 10,
  parameter int unsigned COORD_BITS      = 10
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // apb-style register port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_W-1:0]    paddr,
  input  logic [APB_DATA_W-1:0]    pwdata,
  output logic [APB_DATA_W-1:0]    prdata,
  output logic                     pready,
  // parameter input channel
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [PARAM_FRAC_BITS:0] curve_param_i,
  // curve point output channel
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [COORD_BITS-1:0]    pixel_x_o,
  output logic [COORD_BITS-1:0]    pixel_y_o
);

  localparam int unsigned VAL_W    = COORD_BITS + PARAM_FRAC_BITS;
  localparam int unsigned N_STAGES = 7;
  localparam int unsigned N_TSTG   = 5;
  localparam logic [PARAM_FRAC_BITS:0] FIX_ONE = {1'b1, {PARAM_FRAC_BITS{1'b0}}};

  // control point registers
  logic [COORD_BITS-1:0] ctrl_q [NUM_REGS];
  logic                  wr_en;
  logic [REG_IDX_W-1:0]  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2 +: REG_IDX_W];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        ctrl_q[i] <= '0;
      end
    end else if (wr_en) begin
      ctrl_q[reg_idx] <= pwdata[COORD_BITS-1:0];
    end
  end

  assign prdata = {{(APB_DATA_W-COORD_BITS){1'b0}}, ctrl_q[reg_idx]};

  // stage valids and load enables, enable ripples back from the output
  logic [N_STAGES-1:0] v_q;
  logic [N_STAGES:0]   en;

  always_comb begin
    en[N_STAGES] = out_ready_i;
    for (int k = N_STAGES - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < N_STAGES; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[N_STAGES-1];

  // clamp t and carry t and one minus t alongside the lerp stages
  logic [PARAM_FRAC_BITS:0] t_sat;
  logic [PARAM_FRAC_BITS:0] t_q   [N_TSTG];
  logic [PARAM_FRAC_BITS:0] omt_q [N_TSTG];

  assign t_sat = (curve_param_i > FIX_ONE) ? FIX_ONE : curve_param_i;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      t_q[0]   <= t_sat;
      omt_q[0] <= FIX_ONE - t_sat;
    end
    for (int k = 1; k < N_TSTG; k++) begin
      if (en[k]) begin
        t_q[k]   <= t_q[k-1];
        omt_q[k] <= omt_q[k-1];
      end
    end
  end

  // level zero: control points moved to fixed point
  logic [VAL_W-1:0] val [4][2][4];
  logic [COORD_BITS-1:0] pt_x [4];
  logic [COORD_BITS-1:0] pt_y [4];

  assign pt_x[0] = ctrl_q[REG_P0_X];
  assign pt_y[0] = ctrl_q[REG_P0_Y];
  assign pt_x[1] = ctrl_q[REG_P1_X];
  assign pt_y[1] = ctrl_q[REG_P1_Y];
  assign pt_x[2] = ctrl_q[REG_P2_X];
  assign pt_y[2] = ctrl_q[REG_P2_Y];
  assign pt_x[3] = ctrl_q[REG_P3_X];
  assign pt_y[3] = ctrl_q[REG_P3_Y];

  for (genvar i = 0; i < 4; i++) begin : g_lvl0
    assign val[0][0][i] = {pt_x[i], {PARAM_FRAC_BITS{1'b0}}};
    assign val[0][1][i] = {pt_y[i], {PARAM_FRAC_BITS{1'b0}}};
  end

  // three interpolation levels, each a multiply stage and a sum stage
  for (genvar l = 0; l < 3; l++) begin : g_lvl
    lerp_ctrl_t lvl_ctrl;
    assign lvl_ctrl.mul_en = en[2*l+1];
    assign lvl_ctrl.sum_en = en[2*l+2];
    for (genvar ax = 0; ax < 2; ax++) begin : g_axis
      for (genvar i = 0; i < 4; i++) begin : g_lane
        if (i < 3 - l) begin : g_used
          cbpe_lerp #(
            .VAL_W  (VAL_W),
            .FRAC_W (PARAM_FRAC_BITS)
          ) u_lerp (
            .clk_i  (clk_i),
            .ctrl_i (lvl_ctrl),
            .a_i    (val[l][ax][i]),
            .b_i    (val[l][ax][i+1]),
            .t_i    (t_q[2*l]),
            .omt_i  (omt_q[2*l]),
            .res_o  (val[l+1][ax][i])
          );
        end else begin : g_unused
          assign val[l+1][ax][i] = '0;
        end
      end
    end
  end

  // whole pixels of the final point
  assign pixel_x_o = val[3][0][0][PARAM_FRAC_BITS +: COORD_BITS];
  assign pixel_y_o = val[3][1][0][PARAM_FRAC_BITS +: COORD_BITS];

`ifndef ASSERT_OFF
  // an accepted beat lands in the first stage with t clamped to one
  a_accept_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> v_q[0] && (t_q[0] <= FIX_ONE))
    else $error("accepted beat missing or t not clamped");

  // the two weights of a lerp always add up to one
  a_weights_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[0] |-> ((PARAM_FRAC_BITS+2)'(t_q[0]) + (PARAM_FRAC_BITS+2)'(omt_q[0]))
               == (PARAM_FRAC_BITS+2)'(FIX_ONE))
    else $error("lerp weights do not sum to one");

  // the last multiply stage keeps its beat while the output stage holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[N_STAGES-2] && !en[N_STAGES-1] |=> v_q[N_STAGES-2])
    else $error("beat lost behind a stalled output");
`endif

endmodule

// ===== hdl/cbpe_lerp.sv =====
// one fixed point linear interpolation, two register stages deep
// stage one registers both products, stage two the truncated sum
// depends on cbpe_pkg for the stage enable bundle
module cbpe_lerp import cbpe_pkg::*; #(
  parameter int unsigned VAL_W  = 20,
  parameter int unsigned FRAC_W = 10
) (
  input  logic              clk_i,
  input  lerp_ctrl_t        ctrl_i,
  input  logic [VAL_W-1:0]  a_i,
  input  logic [VAL_W-1:0]  b_i,
  input  logic [FRAC_W:0]   t_i,
  input  logic [FRAC_W:0]   omt_i,
  output logic [VAL_W-1:0]  res_o
);

  localparam int unsigned PROD_W = VAL_W + FRAC_W + 1;
  localparam int unsigned SUM_W  = PROD_W + 1;

  logic [PROD_W-1:0] prod_a_q, prod_b_q;
  logic [SUM_W-1:0]  sum;
  logic [VAL_W-1:0]  res_q;

  // weight each end point
  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_a_q <= PROD_W'(a_i) * PROD_W'(omt_i);
      prod_b_q <= PROD_W'(b_i) * PROD_W'(t_i);
    end
  end

  // add and drop the fraction of the weights
  assign sum = SUM_W'(prod_a_q) + SUM_W'(prod_b_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.sum_en) begin
      res_q <= sum[FRAC_W +: VAL_W];
    end
  end

  assign res_o = res_q;

endmodule

// ===== bench/cubic_bezier_point_eval_tb.sv =====
// self-checking testbench for the cubic bezier point evaluator
// drives control points over the apb-style port and t beats on the input channel
// depends on cbpe_pkg and cubic_bezier_point_eval
`timescale 1ns / 100ps

module cubic_bezier_point_eval_tb;
  import cbpe_pkg::*;

  localparam int unsigned FRAC_BITS    = 10;
  localparam int unsigned COORD_W      = 10;
  localparam int unsigned PARAM_W      = FRAC_BITS + 1;
  localparam int unsigned PARAM_ONE    = 1 << FRAC_BITS;
  localparam int unsigned PARAM_TOP    = (1 << PARAM_W) - 1;
  localparam int unsigned COORD_TOP    = (1 << COORD_W) - 1;
  localparam int unsigned PIPE_LATENCY = 7;
  localparam int unsigned GAP_MAX      = 13;
  localparam int unsigned HOLD_CYCLES  = 60;
  localparam int unsigned IDLE_LIMIT   = 500;
  localparam int unsigned RAND_PHASES  = 6;
  localparam int unsigned PHASE_ITEMS  = 315;

  // idling styles of either side
  typedef enum int unsigned {GAPS_NONE, GAPS_FULL, GAPS_SPARSE} gap_style_e;
  // ways of drawing a control point coordinate
  typedef enum int unsigned {COORD_ANY, COORD_CORNERS, COORD_MIXED} coord_style_e;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } curve_point_t;

  // expected curve points and the control point copy they are computed from
  class curve_point_board;
    logic [COORD_W-1:0] ctrl_x [4];
    logic [COORD_W-1:0] ctrl_y [4];
    curve_point_t expected_points [$];
    int unsigned errors;
    int unsigned params_seen;
    int unsigned points_checked;

    function new();
      foreach (ctrl_x[i]) begin
        ctrl_x[i] = '0;
        ctrl_y[i] = '0;
      end
      errors = 0;
      params_seen = 0;
      points_checked = 0;
    endfunction

    // register write, value cut to the coordinate width
    function void set_coord(logic [REG_IDX_W-1:0] idx, logic [APB_DATA_W-1:0] value);
      case (idx)
        REG_P0_X: ctrl_x[0] = value[COORD_W-1:0];
        REG_P0_Y: ctrl_y[0] = value[COORD_W-1:0];
        REG_P1_X: ctrl_x[1] = value[COORD_W-1:0];
        REG_P1_Y: ctrl_y[1] = value[COORD_W-1:0];
        REG_P2_X: ctrl_x[2] = value[COORD_W-1:0];
        REG_P2_Y: ctrl_y[2] = value[COORD_W-1:0];
        REG_P3_X: ctrl_x[3] = value[COORD_W-1:0];
        REG_P3_Y: ctrl_y[3] = value[COORD_W-1:0];
        default: ;
      endcase
    endfunction

    // three levels of fixed point lerps on one axis
    function logic [COORD_W-1:0] casteljau_axis(logic [COORD_W-1:0] pts [4],
                                                logic [PARAM_W-1:0] t);
      logic [63:0] acc [4];
      logic [63:0] tc;
      tc = (t > PARAM_ONE) ? 64'(PARAM_ONE) : 64'(t);
      for (int i = 0; i < 4; i++) acc[i] = 64'(pts[i]) << FRAC_BITS;
      for (int lvl = 3; lvl > 0; lvl--) begin
        for (int i = 0; i < lvl; i++) begin
          acc[i] = (acc[i] * (64'(PARAM_ONE) - tc) + acc[i+1] * tc) >> FRAC_BITS;
        end
      end
      return COORD_W'(acc[0] >> FRAC_BITS);
    endfunction

    function void note_param(logic [PARAM_W-1:0] t);
      curve_point_t pt;
      pt.x = casteljau_axis(ctrl_x, t);
      pt.y = casteljau_axis(ctrl_y, t);
      expected_points.push_back(pt);
      params_seen++;
    endfunction

    function void check_point(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
      curve_point_t pt;
      if (expected_points.size() == 0) begin
        $display("%0t: unexpected point x=%0d y=%0d", $realtime, x, y);
        errors++;
        return;
      end
      pt = expected_points.pop_front();
      points_checked++;
      if (x !== pt.x) begin
        $display("%0t: pixel_x mismatch expected %0d actual %0d", $realtime, pt.x, x);
        errors++;
      end
      if (y !== pt.y) begin
        $display("%0t: pixel_y mismatch expected %0d actual %0d", $realtime, pt.y, y);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_points.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;
  logic in_valid_i;
  logic in_ready_o;
  logic [PARAM_W-1:0] curve_param_i;
  logic out_valid_o;
  logic out_ready_i;
  logic [COORD_W-1:0] pixel_x_o;
  logic [COORD_W-1:0] pixel_y_o;

  curve_point_board board;
  gap_style_e send_style;
  gap_style_e recv_style;
  logic hold_output;
  int unsigned settings_loaded;

  cubic_bezier_point_eval #(
    .PARAM_FRAC_BITS(FRAC_BITS),
    .COORD_BITS     (COORD_W)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .curve_param_i(curve_param_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pixel_x_o    (pixel_x_o),
    .pixel_y_o    (pixel_y_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // watchdog on cycles without any accepted beat
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no beat accepted for %0d cycles", $realtime, IDLE_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  function automatic int unsigned draw_gap(gap_style_e style);
    case (style)
      GAPS_NONE: return 0;
      GAPS_FULL: return $urandom_range(0, GAP_MAX);
      default:   return ($urandom_range(0, 3) == 0) ? $urandom_range(1, GAP_MAX) : 0;
    endcase
  endfunction

  // mostly inside [0, 1.0], some above 1.0 and a few exact ends
  function automatic logic [PARAM_W-1:0] draw_param();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return PARAM_W'(PARAM_ONE);
    if (pick == 1) return '0;
    if (pick < 4) return PARAM_W'($urandom_range(PARAM_ONE + 1, PARAM_TOP));
    return PARAM_W'($urandom_range(0, PARAM_ONE));
  endfunction

  // coordinate in the low bits, random junk above it
  function automatic logic [APB_DATA_W-1:0] draw_coord_word(coord_style_e style);
    logic [APB_DATA_W-1:0] word;
    int unsigned coord;
    int unsigned pick;
    pick = $urandom_range(0, 3);
    case (style)
      COORD_ANY:     coord = $urandom_range(0, COORD_TOP);
      COORD_CORNERS: coord = pick[0] ? COORD_TOP : 0;
      default:       coord = (pick == 0) ? 0 : (pick == 1) ? COORD_TOP
                                                           : $urandom_range(0, COORD_TOP);
    endcase
    word = $urandom();
    word[COORD_W-1:0] = COORD_W'(coord);
    return word;
  endfunction

  // one apb write: setup cycle then access cycle
  task automatic write_coord(input logic [REG_IDX_W-1:0] idx,
                             input logic [APB_DATA_W-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board.set_coord(idx, value);
  endtask

  task automatic load_curve(input logic [APB_DATA_W-1:0] x0, y0, x1, y1, x2, y2, x3, y3);
    write_coord(REG_P0_X, x0);
    write_coord(REG_P0_Y, y0);
    write_coord(REG_P1_X, x1);
    write_coord(REG_P1_Y, y1);
    write_coord(REG_P2_X, x2);
    write_coord(REG_P2_Y, y2);
    write_coord(REG_P3_X, x3);
    write_coord(REG_P3_Y, y3);
    settings_loaded++;
  endtask

  task automatic load_random_curve(input coord_style_e style);
    load_curve(draw_coord_word(style), draw_coord_word(style), draw_coord_word(style),
               draw_coord_word(style), draw_coord_word(style), draw_coord_word(style),
               draw_coord_word(style), draw_coord_word(style));
  endtask

  // offer one t beat and wait for it to be taken
  task automatic send_param(input logic [PARAM_W-1:0] t);
    int unsigned gap;
    gap = draw_gap(send_style);
    if (gap != 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    curve_param_i <= t;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_param(t);
  endtask

  // stop offering and wait until every point is back
  task automatic drain_points();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (PIPE_LATENCY + 2) @(posedge clk_i);
  endtask

  // result side: random stalls, one long hold on request
  task automatic collect_points();
    int unsigned stall;
    forever begin
      stall = draw_gap(recv_style);
      if (hold_output) begin
        stall = HOLD_CYCLES;
        hold_output = 1'b0;
      end
      if (stall != 0) begin
        @(negedge clk_i);
        out_ready_i <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      board.check_point(pixel_x_o, pixel_y_o);
    end
  endtask

  // stimulus
  initial begin
    int unsigned ends_params [2];
    int unsigned corner_params [13];
    int unsigned full_params [5];
    ends_params   = '{0, PARAM_TOP};
    corner_params = '{0, 1, 2, 24, 511, 512, 513, 1000, PARAM_ONE - 1, PARAM_ONE,
                      PARAM_ONE + 1, 1536, PARAM_TOP};
    full_params   = '{0, 512, 777, PARAM_ONE, PARAM_TOP};
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_valid_i    = 1'b0;
    curve_param_i = '0;
    out_ready_i   = 1'b0;
    hold_output   = 1'b0;
    send_style    = GAPS_NONE;
    recv_style    = GAPS_NONE;
    settings_loaded = 1;
    board = new();
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    fork
      collect_points();
    join_none

    // control points straight out of reset are all zero
    foreach (ends_params[i]) send_param(PARAM_W'(ends_params[i]));
    drain_points();

    // zigzag between the coordinate extremes, junk in the upper data bits
    send_style = GAPS_SPARSE;
    recv_style = GAPS_SPARSE;
    load_curve(32'hABCD_FC00, 32'hFFFF_FFFF, 32'h0000_03FF, 32'h5A5A_5C00,
               32'h0000_0000, 32'hFFFF_FBFF | 32'h0000_03FF, 32'hFFFF_FFFF, 32'h8000_0000);
    foreach (corner_params[i]) send_param(PARAM_W'(corner_params[i]));
    drain_points();

    // every control point at the top coordinate
    load_curve(32'h3FF, 32'h3FF, 32'h3FF, 32'h3FF, 32'h3FF, 32'h3FF, 32'h3FF, 32'h3FF);
    foreach (full_params[i]) send_param(PARAM_W'(full_params[i]));
    drain_points();

    // random phases with a fresh curve and idling mix each
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      load_random_curve(coord_style_e'(phase % 3));
      send_style = gap_style_e'(phase % 3);
      recv_style = gap_style_e'((phase + 1) % 3);
      // fill the pipe against a stalled receiver
      if (send_style == GAPS_NONE) hold_output = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) send_param(draw_param());
      drain_points();
    end

    repeat (PIPE_LATENCY + 5) @(posedge clk_i);
    if (board.pending() != 0) begin
      $display("%0t: %0d expected points never arrived", $realtime, board.pending());
      board.errors++;
    end
    $display("ran %0d t values over %0d control point settings, %0d points checked",
             board.params_seen, settings_loaded, board.points_checked);
    $display("t covered 0, 1.0, values above 1.0 and the full 11-bit field");
    if (board.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
